### hw/rtl/utf8d_pkg.sv
package utf8d_pkg;

  // byte classes
  localparam logic [7:0] LEAD_MIN  = 8'hC0;
  localparam logic [7:0] LEAD_MAX  = 8'hFD;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  // result queue and held continuation sizes
  localparam int MAX_UNITS  = 6;
  localparam int HELD_DEPTH = 4;

  // source byte counts
  localparam logic [2:0] LEN_SINGLE = 3'd1;

  // one result item
  typedef struct packed {
    logic [15:0] code;
    logic [2:0]  len;
    logic        fb;
  } unit_t;

  // every result caused by one input byte
  typedef struct packed {
    unit_t [MAX_UNITS-1:0] slot;
    logic  [2:0]           count;
  } burst_t;

endpackage

### hw/rtl/utf8_to_ucs2_decoder.sv
// UTF-8 to 16-bit code unit decoder.
// Input channel (in_valid/in_ready) carries one text byte per request with
// end_of_text marking the final byte. Output channel (out_valid/out_ready)
// carries one code unit per request with source_bytes, raw_fallback and
// last_result, which flags the final unit caused by a given input byte.
// Each accepted byte is decoded in the cycle it is accepted; its results
// (zero to six) are loaded into a shift queue and appear on the output the
// next cycle. Throughput is one byte per cycle while each byte yields at
// most one unit and the receiver holds out_ready high.
// A byte that yields more than one unit (a broken or flushed sequence) holds
// the input while the queue drains, one unit per cycle when out_ready is high.
// The input is ready whenever the queue is empty or its last unit is being
// taken, so a stalled receiver stops the input after at most one byte.
// Reset closes any open sequence and empties the queue.
module utf8_to_ucs2_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic [2:0]  source_bytes,
  output logic        raw_fallback,
  output logic        last_result
);
  import utf8d_pkg::*;

  burst_t burst;
  unit_t  head;
  logic   accept;

  assign accept = in_valid && in_ready;

  // decode step and sequence state
  utf8d_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .burst       (burst)
  );

  // result queue
  utf8d_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .burst     (burst),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .head_last (last_result)
  );

  assign code_unit    = head.code;
  assign source_bytes = head.len;
  assign raw_fallback = head.fb;

endmodule

### hw/rtl/utf8d_core.sv
module utf8d_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            end_of_text,
  output utf8d_pkg::burst_t burst
);
  import utf8d_pkg::*;

  // sequence state
  logic [7:0]  lead_byte;
  logic [2:0]  expected_length;
  logic [2:0]  pending_count;
  logic [15:0] accumulated_code;
  logic [7:0]  held [HELD_DEPTH];

  logic [7:0]  lead_byte_next;
  logic [2:0]  expected_length_next;
  logic [2:0]  pending_count_next;
  logic [15:0] accumulated_code_next;

  logic        seq_open;
  logic        is_cont;
  logic        is_lead;
  logic        complete;
  logic        store;
  logic        fresh;
  logic        fresh_valid;
  logic [2:0]  flush_cnt;
  logic [15:0] acc_new;
  logic [2:0]  lead_len;
  logic [4:0]  lead_bits;
  logic [7:0]  held_view [HELD_DEPTH];
  unit_t       fresh_unit;

  // byte classification
  assign seq_open = (expected_length != 3'd0);
  assign is_cont  = (in_byte[7:6] == CONT_TAG);
  assign is_lead  = (in_byte >= LEAD_MIN) && (in_byte <= LEAD_MAX);
  assign acc_new  = {accumulated_code[9:0], in_byte[5:0]};
  assign complete = seq_open && is_cont &&
                    ({1'b0, pending_count} + 4'd2 >= {1'b0, expected_length});
  assign store    = seq_open && is_cont && !complete;
  assign fresh    = !seq_open || !is_cont;

  // sequence length and payload from a lead byte
  always_comb begin
    casez (in_byte)
      8'b110?????: begin lead_len = 3'd2; lead_bits = in_byte[4:0]; end
      8'b1110????: begin lead_len = 3'd3; lead_bits = {1'b0, in_byte[3:0]}; end
      8'b11110???: begin lead_len = 3'd4; lead_bits = {2'b0, in_byte[2:0]}; end
      8'b111110??: begin lead_len = 3'd5; lead_bits = {3'b0, in_byte[1:0]}; end
      default:     begin lead_len = 3'd6; lead_bits = {4'b0, in_byte[0]}; end
    endcase
  end

  // held bytes including the one being stored now
  always_comb begin
    for (int k = 0; k < HELD_DEPTH; k++) begin
      held_view[k] = (store && pending_count[1:0] == 2'(k)) ? in_byte : held[k];
    end
  end

  // number of raw units from a flushed sequence
  always_comb begin
    if (store && end_of_text) begin
      flush_cnt = pending_count + 3'd2;
    end else if (seq_open && !is_cont) begin
      flush_cnt = pending_count + 3'd1;
    end else begin
      flush_cnt = 3'd0;
    end
  end

  // unit from a byte taken with no sequence open or breaking an open one
  always_comb begin
    if (is_lead) begin
      fresh_valid = end_of_text;
      fresh_unit  = '{code: {8'h00, in_byte}, len: LEN_SINGLE, fb: 1'b1};
    end else begin
      fresh_valid = 1'b1;
      fresh_unit  = '{code: {8'h00, in_byte}, len: LEN_SINGLE, fb: 1'b0};
    end
  end

  // assemble the result list
  always_comb begin
    burst = '0;
    if (complete) begin
      burst.slot[0] = '{code: acc_new, len: expected_length, fb: 1'b0};
      burst.count   = 3'd1;
    end else begin
      for (int i = 0; i < MAX_UNITS; i++) begin
        if (3'(i) < flush_cnt) begin
          if (i == 0) begin
            burst.slot[i] = '{code: {8'h00, lead_byte}, len: LEN_SINGLE, fb: 1'b1};
          end else begin
            burst.slot[i] = '{code: {8'h00, held_view[2'(i - 1)]}, len: LEN_SINGLE,
                              fb: 1'b1};
          end
        end else if (3'(i) == flush_cnt && fresh && fresh_valid) begin
          burst.slot[i] = fresh_unit;
        end
      end
      burst.count = flush_cnt + {2'b00, fresh && fresh_valid};
    end
  end

  // next sequence state
  always_comb begin
    lead_byte_next        = lead_byte;
    expected_length_next  = 3'd0;
    pending_count_next    = 3'd0;
    accumulated_code_next = 16'h0000;
    if (store) begin
      if (!end_of_text) begin
        expected_length_next  = expected_length;
        pending_count_next    = pending_count + 3'd1;
        accumulated_code_next = acc_new;
      end
    end else if (fresh && is_lead) begin
      lead_byte_next = in_byte;
      if (!end_of_text) begin
        expected_length_next  = lead_len;
        accumulated_code_next = {11'b0, lead_bits};
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte        <= 8'h00;
      expected_length  <= 3'd0;
      pending_count    <= 3'd0;
      accumulated_code <= 16'h0000;
    end else if (accept) begin
      lead_byte        <= lead_byte_next;
      expected_length  <= expected_length_next;
      pending_count    <= pending_count_next;
      accumulated_code <= accumulated_code_next;
    end
  end

  // held continuation bytes
  always_ff @(posedge clk) begin
    if (accept && store) begin
      held[pending_count[1:0]] <= in_byte;
    end
  end

endmodule

### hw/rtl/utf8d_drain.sv
module utf8d_drain (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  utf8d_pkg::burst_t burst,
  output logic              out_valid,
  input  logic              out_ready,
  output utf8d_pkg::unit_t  head,
  output logic              head_last
);
  import utf8d_pkg::*;

  unit_t      slot [MAX_UNITS];
  logic [2:0] count;
  logic       load;
  logic       take;

  // handshake
  assign out_valid = (count != 3'd0);
  assign take      = out_valid && out_ready;
  assign in_ready  = (count == 3'd0) || ((count == 3'd1) && out_ready);
  assign load      = in_valid && in_ready;
  assign head      = slot[0];
  assign head_last = (count == 3'd1);

  // result count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (load) begin
      count <= burst.count;
    end else if (take) begin
      count <= count - 3'd1;
    end
  end

  // result shift queue
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_UNITS; i++) begin
        slot[i] <= burst.slot[i];
      end
    end else if (take) begin
      for (int i = 0; i < MAX_UNITS - 1; i++) begin
        slot[i] <= slot[i + 1];
      end
    end
  end

endmodule
